// ----- src/pst_pkg.sv -----
package pst_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int NAME_BITS   = 128;
    localparam int FULL_BITS   = 128;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = 8;
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 16;

    localparam logic [FULL_BITS-1:0] NAME_MASK = ~({FULL_BITS{1'b1}} >> NAME_BITS);
    localparam logic [LEN_W-1:0]     LEN_MAX   = LEN_W'(NAME_BITS);

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_MATCH   = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_SCAN,
        S_READ,
        S_CHECK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    load_req;
        logic    cmp;
        logic    pick;
        logic    len_inc;
        logic    write_entry;
        logic    clear_entry;
        logic    out_load;
        logic    out_from_rd;
        t_status out_status;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic sel_any;
        logic slen_end;
        logic free_any;
        logic rd_match;
    } t_stat;

    function automatic logic [FULL_BITS-1:0] name_mask(input logic [LEN_W-1:0] k);
        name_mask = ~({FULL_BITS{1'b1}} >> k) & NAME_MASK;
    endfunction

endpackage

// ----- src/pst_ctrl.sv -----
module pst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  logic          i_out_last,
    input  pst_pkg::t_stat i_stat,
    output pst_pkg::t_cmd  o_cmd
);
    import pst_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CMP;
            end
            S_CMP: begin
                if (i_stat.req == REQ_NONE) n_state = S_OUT;
                else n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.sel_any) begin
                    n_state = S_READ;
                end else if (i_stat.req == REQ_FIND) begin
                    if (i_stat.slen_end) n_state = S_OUT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_READ: n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.req == REQ_FIND || i_stat.rd_match) n_state = S_OUT;
                else n_state = S_SCAN;
            end
            S_OUT: begin
                if (i_out_ready) n_state = i_out_last ? S_IDLE : S_SCAN;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_req = i_in_valid;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_stat.req == REQ_NONE) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_DONE;
                end
            end
            S_SCAN: begin
                if (i_stat.sel_any) begin
                    o_cmd.pick = 1'b1;
                end else if (i_stat.req == REQ_FIND) begin
                    if (i_stat.slen_end) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = ST_NOMATCH;
                    end else begin
                        o_cmd.len_inc = 1'b1;
                    end
                end else begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.req == REQ_ADD) begin
                        if (i_stat.free_any) begin
                            o_cmd.write_entry = 1'b1;
                            o_cmd.out_status  = ST_DONE;
                        end else begin
                            o_cmd.out_status  = ST_FULL;
                        end
                    end else begin
                        o_cmd.out_status = ST_DONE;
                    end
                end
            end
            S_READ: ;
            S_CHECK: begin
                if (i_stat.req == REQ_FIND) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_from_rd = 1'b1;
                    o_cmd.out_status  = ST_MATCH;
                end else if (i_stat.rd_match) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_status  = ST_DONE;
                    o_cmd.clear_entry = (i_stat.req == REQ_REMOVE);
                end
            end
            S_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end

endmodule

// ----- src/pst_dp.sv -----
module pst_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [1:0]                 i_req_type,
    input  logic [63:0]                i_name_hi,
    input  logic [63:0]                i_name_lo,
    input  logic [7:0]                 i_prefix_len,
    input  logic [pst_pkg::ADDR_W-1:0] i_remote_addr,
    input  logic [pst_pkg::PORT_W-1:0] i_remote_port,
    input  pst_pkg::t_cmd              i_cmd,
    output pst_pkg::t_stat             o_stat,
    output logic [1:0]                 o_status,
    output logic [pst_pkg::ADDR_W-1:0] o_out_addr,
    output logic [pst_pkg::PORT_W-1:0] o_out_port,
    output logic [7:0]                 o_match_len,
    output logic                       o_last
);
    import pst_pkg::*;

    logic                 r_valid [TABLE_DEPTH];
    logic [FULL_BITS-1:0] r_pfx   [TABLE_DEPTH];
    logic [LEN_W-1:0]     r_len   [TABLE_DEPTH];
    logic [ADDR_W+PORT_W-1:0] r_mem [TABLE_DEPTH];
    logic [ADDR_W+PORT_W-1:0] r_rd;

    t_req                 r_req;
    logic [FULL_BITS-1:0] r_name;
    logic [LEN_W-1:0]     r_plen;
    logic [ADDR_W-1:0]    r_raddr;
    logic [PORT_W-1:0]    r_rport;
    logic [LEN_W-1:0]     r_slen;
    logic [TABLE_DEPTH-1:0] r_cand;
    logic [IDX_W-1:0]     r_idx;

    t_status              r_status;
    logic [ADDR_W-1:0]    r_oaddr;
    logic [PORT_W-1:0]    r_oport;
    logic [LEN_W-1:0]     r_olen;
    logic                 r_olast;

    logic [LEN_W-1:0]       plen_sat;
    logic [FULL_BITS-1:0]   in_name;
    logic [TABLE_DEPTH-1:0] cmp_vec;
    logic [TABLE_DEPTH-1:0] sel;
    logic [TABLE_DEPTH-1:0] free_vec;
    logic [IDX_W-1:0]       sel_idx;
    logic [IDX_W-1:0]       free_idx;

    assign plen_sat = (i_prefix_len > LEN_MAX) ? LEN_MAX : i_prefix_len;
    assign in_name  = {i_name_hi, i_name_lo};

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (r_req == REQ_FIND) begin
                cmp_vec[i] = r_valid[i] && (r_pfx[i] == (r_name & name_mask(r_len[i])));
                sel[i]     = r_cand[i] && (r_len[i] == r_slen);
            end else begin
                cmp_vec[i] = r_valid[i] && (r_len[i] == r_plen) && (r_pfx[i] == r_name);
                sel[i]     = r_cand[i];
            end
            free_vec[i] = !r_valid[i];
        end
    end

    always_comb begin
        sel_idx  = '0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (sel[i])      sel_idx  = IDX_W'(i);
            if (free_vec[i]) free_idx = IDX_W'(i);
        end
    end

    assign o_stat.req      = r_req;
    assign o_stat.sel_any  = |sel;
    assign o_stat.slen_end = (r_slen == LEN_MAX);
    assign o_stat.free_any = |free_vec;
    assign o_stat.rd_match = (r_rd == {r_raddr, r_rport});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) r_valid[i] <= 1'b0;
        end else if (i_cmd.write_entry) begin
            r_valid[free_idx] <= 1'b1;
        end else if (i_cmd.clear_entry) begin
            r_valid[r_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry) begin
            r_pfx[free_idx] <= r_name;
            r_len[free_idx] <= r_plen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry) r_mem[free_idx] <= {r_raddr, r_rport};
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req   <= t_req'(i_req_type);
            r_name  <= (t_req'(i_req_type) == REQ_FIND) ? (in_name & NAME_MASK)
                                                        : (in_name & name_mask(plen_sat));
            r_plen  <= plen_sat;
            r_raddr <= i_remote_addr;
            r_rport <= i_remote_port;
            r_slen  <= '0;
        end
        if (i_cmd.len_inc) r_slen <= r_slen + LEN_W'(1);
        if (i_cmd.cmp) r_cand <= cmp_vec;
        if (i_cmd.pick) begin
            r_cand[sel_idx] <= 1'b0;
            r_idx           <= sel_idx;
        end
        if (i_cmd.out_load) begin
            r_status <= i_cmd.out_status;
            if (i_cmd.out_from_rd) begin
                r_oaddr <= r_rd[ADDR_W+PORT_W-1:PORT_W];
                r_oport <= r_rd[PORT_W-1:0];
                r_olen  <= r_slen;
                r_olast <= ~|r_cand;
            end else begin
                r_oaddr <= '0;
                r_oport <= '0;
                r_olen  <= '0;
                r_olast <= 1'b1;
            end
        end
    end

    assign o_status    = r_status;
    assign o_out_addr  = r_oaddr;
    assign o_out_port  = r_oport;
    assign o_match_len = r_olen;
    assign o_last      = r_olast;

endmodule

// ----- src/prefix_subscription_table_core.sv -----
// Subscription table of 64 prefix entries; one request is handled at a time.
// An add or remove checks, one at a time, each stored entry with the same prefix
// and length whose address/port may differ, and stops as soon as one matches
// in full. That address/port check reads the entry RAM one slot at a time.
// A find steps through the prefix lengths 0..128 over the parallel entry compare.
// With matches it does one RAM read for each reported match.
// A result is held until i_out_ready takes it.
// The next request is taken once the last result has been transferred.
module prefix_subscription_table_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_req_type,
    input  logic [63:0]                i_name_hi,
    input  logic [63:0]                i_name_lo,
    input  logic [7:0]                 i_prefix_len,
    input  logic [31:0]                i_remote_addr,
    input  logic [15:0]                i_remote_port,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic [31:0]                o_out_addr,
    output logic [15:0]                o_out_port,
    output logic [7:0]                 o_match_len,
    output logic                       o_last
);
    import pst_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_last  (o_last),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pst_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_type    (i_req_type),
        .i_name_hi     (i_name_hi),
        .i_name_lo     (i_name_lo),
        .i_prefix_len  (i_prefix_len),
        .i_remote_addr (i_remote_addr),
        .i_remote_port (i_remote_port),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_status      (o_status),
        .o_out_addr    (o_out_addr),
        .o_out_port    (o_out_port),
        .o_match_len   (o_match_len),
        .o_last        (o_last)
    );

endmodule

// ----- src/pst_checker.sv -----
module pst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [31:0] o_out_addr,
    input logic [15:0] o_out_port,
    input logic [7:0]  o_match_len,
    input logic        o_last
);
    import pst_pkg::*;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_out_valid)
        else $error("result shown in the cycle after a request transfer");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_MATCH) |-> o_last)
        else $error("non-match result without last");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result withdrawn before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            ($stable(o_status) && $stable(o_out_addr) && $stable(o_out_port) &&
             $stable(o_match_len) && $stable(o_last)))
        else $error("result changed before transfer");

endmodule

bind prefix_subscription_table_core pst_checker u_pst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_out_addr  (o_out_addr),
    .o_out_port  (o_out_port),
    .o_match_len (o_match_len),
    .o_last      (o_last)
);
